// ===== hw/rtl/dram_address_field_mapper_assert.svh =====
// Assertion macros shared by the address mapper RTL.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef DRAM_ADDRESS_FIELD_MAPPER_ASSERT_SVH
`define DRAM_ADDRESS_FIELD_MAPPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DAFM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("address mapper check failed");

// Next-cycle implication, checked outside reset.
`define DAFM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("address mapper check failed");

`endif

// ===== hw/rtl/dafm_pkg.sv =====
// Shared constants, register indexes, tag codes and pipeline types
// for the DRAM address field mapper. No dependencies.
`default_nettype none

package dafm_pkg;

  localparam int ADDR_BITS    = 64;
  localparam int NUM_POS      = 64;
  localparam int NUM_FIELDS   = 8;
  localparam int NUM_SPLIT    = 5;
  localparam int CHUNK_W      = 16;
  localparam int NUM_CHUNKS   = NUM_POS / CHUNK_W;
  localparam int NUM_TAG_REGS = 4;
  localparam int TAGS_PER_REG = 16;
  localparam int TAG_W        = 4;
  localparam int RADIX_W      = 9;
  localparam int ID_W         = 32;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CNT_W        = 5;
  localparam int OFF_W        = 7;

  localparam int DIV_STEPS      = 8;
  localparam int DIV_STAGES_PER = ID_W / DIV_STEPS;
  localparam int NUM_DIVS       = 4;
  localparam int GATHER_STG     = 0;
  localparam int MERGE_STG      = 1;
  localparam int H_CH_STG       = 2;
  localparam int H_RANK_STG     = 3;
  localparam int H_GROUP_STG    = 4;
  localparam int H_BANK_STG     = 5;
  localparam int FIRST_DIV_STG  = 1;
  localparam int LAST_DIV_STG   = FIRST_DIV_STG + NUM_DIVS * DIV_STAGES_PER - 1;
  localparam int OFFS_STG       = LAST_DIV_STG + 1;
  localparam int DEP_STG        = OFFS_STG + 1;
  localparam int NUM_STAGES     = DEP_STG + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TAGS_0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAGS_1  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAGS_2  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAGS_3  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BANKS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANKS   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PCHS    = 4'd7;

  // Field index f is selected by tag code f + 1.
  localparam int F_CH    = 0;
  localparam int F_PCH   = 1;
  localparam int F_RANK  = 2;
  localparam int F_GROUP = 3;
  localparam int F_BANK  = 4;
  localparam int F_ROW   = 5;
  localparam int F_COL   = 6;
  localparam int F_LINE  = 7;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][NUM_POS-1:0] mask;
    logic [RADIX_W-1:0]                 rad_b;
    logic [RADIX_W-1:0]                 rad_g;
    logic [RADIX_W-1:0]                 rad_r;
    logic [RADIX_W-1:0]                 rad_p;
  } cfg_t;

  typedef struct packed {
    logic                                         mode;
    logic [ID_W-1:0]                              num;
    logic [RADIX_W-1:0]                           rem;
    logic [NUM_DIVS-1:0][RADIX_W-1:0]             dpart;
    logic [NUM_FIELDS-1:0][NUM_POS-1:0]           fld;
    logic [NUM_FIELDS-1:0][NUM_CHUNKS-1:0][CNT_W-1:0] cnt;
    logic [ID_W-1:0]                              acc;
    logic [ID_W-1:0]                              frank;
    logic [NUM_POS-1:0]                           built;
  } pipe_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dafm_cfg.sv =====
// Configuration registers of the address mapper and the decoded field
// masks and radices. Depends on dafm_pkg.
`default_nettype none

module dafm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dafm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dafm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dafm_pkg::cfg_t                        cfg
);

  logic [dafm_pkg::NUM_TAG_REGS-1:0][dafm_pkg::CFG_DATA_W-1:0] tags_r;
  logic [dafm_pkg::RADIX_W-1:0] rad_b_r, rad_g_r, rad_r_r, rad_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tags_r  <= '0;
      rad_b_r <= 9'd1;
      rad_g_r <= 9'd1;
      rad_r_r <= 9'd1;
      rad_p_r <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dafm_pkg::CFG_TAGS_0: tags_r[0] <= cfg_data;
        dafm_pkg::CFG_TAGS_1: tags_r[1] <= cfg_data;
        dafm_pkg::CFG_TAGS_2: tags_r[2] <= cfg_data;
        dafm_pkg::CFG_TAGS_3: tags_r[3] <= cfg_data;
        dafm_pkg::CFG_BANKS:  rad_b_r <= cfg_data[dafm_pkg::RADIX_W-1:0];
        dafm_pkg::CFG_GROUPS: rad_g_r <= cfg_data[dafm_pkg::RADIX_W-1:0];
        dafm_pkg::CFG_RANKS:  rad_r_r <= cfg_data[dafm_pkg::RADIX_W-1:0];
        dafm_pkg::CFG_PCHS:   rad_p_r <= cfg_data[dafm_pkg::RADIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [dafm_pkg::TAG_W-1:0] tag;
    tag = '0;
    cfg = '0;
    for (int pos = 0; pos < dafm_pkg::NUM_POS; pos++) begin
      tag = tags_r[pos / dafm_pkg::TAGS_PER_REG]
                  [(pos % dafm_pkg::TAGS_PER_REG) * dafm_pkg::TAG_W +: dafm_pkg::TAG_W];
      for (int f = 0; f < dafm_pkg::NUM_FIELDS; f++) begin
        cfg.mask[f][pos] = (pos < dafm_pkg::ADDR_BITS) && (tag == 4'(f + 1));
      end
    end
    cfg.rad_b = (rad_b_r == '0) ? 9'd1 : rad_b_r;
    cfg.rad_g = (rad_g_r == '0) ? 9'd1 : rad_g_r;
    cfg.rad_r = (rad_r_r == '0) ? 9'd1 : rad_r_r;
    cfg.rad_p = (rad_p_r == '0) ? 9'd1 : rad_p_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dafm_pipe.sv =====
// Staged datapath of the address mapper: gather, Horner sums, radix
// division and bit scatter, with per-stage valid bits. Depends on dafm_pkg.
`default_nettype none

module dafm_pipe (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dafm_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_mode,
  input  wire logic [dafm_pkg::NUM_POS-1:0] in_phys_address,
  input  wire logic [dafm_pkg::ID_W-1:0]    in_bank_id_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output dafm_pkg::pipe_t                   out_res
);

  localparam int N = dafm_pkg::NUM_STAGES;

  function automatic dafm_pkg::pipe_t stage_fn(int s, dafm_pkg::pipe_t p,
                                               dafm_pkg::cfg_t c);
    dafm_pkg::pipe_t q;
    logic [dafm_pkg::NUM_POS-1:0] addr;
    logic [dafm_pkg::NUM_POS-1:0] acc;
    logic [dafm_pkg::CHUNK_W-1:0] ck;
    logic [dafm_pkg::CHUNK_W-1:0] m16;
    logic [dafm_pkg::CNT_W-1:0] rk;
    logic [dafm_pkg::OFF_W-1:0] off;
    logic [dafm_pkg::RADIX_W:0] rem10;
    logic [dafm_pkg::RADIX_W-1:0] d;
    logic [dafm_pkg::NUM_SPLIT-1:0][dafm_pkg::ID_W-1:0] pv;
    int k;
    q = p;
    addr = p.fld[0];
    acc = '0;
    ck = '0;
    m16 = '0;
    rk = '0;
    off = '0;
    rem10 = '0;
    d = '0;
    pv = '0;
    k = 0;
    if (s == dafm_pkg::GATHER_STG) begin
      for (int f = 0; f < dafm_pkg::NUM_FIELDS; f++) begin
        for (int cc = 0; cc < dafm_pkg::NUM_CHUNKS; cc++) begin
          m16 = c.mask[f][cc*dafm_pkg::CHUNK_W +: dafm_pkg::CHUNK_W];
          ck = '0;
          for (int i = 0; i < dafm_pkg::CHUNK_W; i++) begin
            rk = 5'($countones(m16 & ((16'd1 << i) - 16'd1)));
            if (m16[i] && addr[cc*dafm_pkg::CHUNK_W + i]) begin
              ck[rk[3:0]] = 1'b1;
            end
          end
          q.fld[f][cc*dafm_pkg::CHUNK_W +: dafm_pkg::CHUNK_W] = ck;
          q.cnt[f][cc] = 5'($countones(m16));
        end
      end
    end
    if (s == dafm_pkg::MERGE_STG) begin
      for (int f = 0; f < dafm_pkg::NUM_FIELDS; f++) begin
        acc = '0;
        off = '0;
        for (int cc = 0; cc < dafm_pkg::NUM_CHUNKS; cc++) begin
          acc = acc | ({48'd0, p.fld[f][cc*dafm_pkg::CHUNK_W +: dafm_pkg::CHUNK_W]} << off);
          off = off + 7'(p.cnt[f][cc]);
        end
        q.fld[f] = acc;
      end
    end
    if (s == dafm_pkg::H_CH_STG) begin
      q.acc = p.fld[dafm_pkg::F_CH][dafm_pkg::ID_W-1:0] * 32'(c.rad_p)
              + p.fld[dafm_pkg::F_PCH][dafm_pkg::ID_W-1:0];
    end
    if (s == dafm_pkg::H_RANK_STG) begin
      q.acc = p.acc * 32'(c.rad_r) + p.fld[dafm_pkg::F_RANK][dafm_pkg::ID_W-1:0];
      q.frank = q.acc;
    end
    if (s == dafm_pkg::H_GROUP_STG) begin
      q.acc = p.acc * 32'(c.rad_g) + p.fld[dafm_pkg::F_GROUP][dafm_pkg::ID_W-1:0];
    end
    if (s == dafm_pkg::H_BANK_STG) begin
      q.acc = p.acc * 32'(c.rad_b) + p.fld[dafm_pkg::F_BANK][dafm_pkg::ID_W-1:0];
    end
    if (s >= dafm_pkg::FIRST_DIV_STG && s <= dafm_pkg::LAST_DIV_STG) begin
      k = (s - dafm_pkg::FIRST_DIV_STG) / dafm_pkg::DIV_STAGES_PER;
      if (((s - dafm_pkg::FIRST_DIV_STG) % dafm_pkg::DIV_STAGES_PER) == 0 && k > 0) begin
        q.dpart[k-1] = p.rem;
        q.rem = '0;
      end
      unique case (k)
        0: d = c.rad_b;
        1: d = c.rad_g;
        2: d = c.rad_r;
        default: d = c.rad_p;
      endcase
      for (int st = 0; st < dafm_pkg::DIV_STEPS; st++) begin
        rem10 = {q.rem, q.num[dafm_pkg::ID_W-1]};
        q.num = {q.num[dafm_pkg::ID_W-2:0], 1'b0};
        if (rem10 >= {1'b0, d}) begin
          rem10 = rem10 - {1'b0, d};
          q.num[0] = 1'b1;
        end
        q.rem = rem10[dafm_pkg::RADIX_W-1:0];
      end
    end
    if (s == dafm_pkg::OFFS_STG && p.mode) begin
      pv[dafm_pkg::F_CH]    = p.num;
      pv[dafm_pkg::F_PCH]   = 32'(p.rem);
      pv[dafm_pkg::F_RANK]  = 32'(p.dpart[2]);
      pv[dafm_pkg::F_GROUP] = 32'(p.dpart[1]);
      pv[dafm_pkg::F_BANK]  = 32'(p.dpart[0]);
      for (int f = 0; f < dafm_pkg::NUM_SPLIT; f++) begin
        for (int cc = 0; cc < dafm_pkg::NUM_CHUNKS; cc++) begin
          off = 7'($countones(c.mask[f] & ((64'd1 << (cc*dafm_pkg::CHUNK_W)) - 64'd1)));
          q.fld[f][cc*dafm_pkg::CHUNK_W +: dafm_pkg::CHUNK_W] = 16'(pv[f] >> off);
        end
      end
    end
    if (s == dafm_pkg::DEP_STG) begin
      q.built = '0;
      if (p.mode) begin
        for (int cc = 0; cc < dafm_pkg::NUM_CHUNKS; cc++) begin
          for (int i = 0; i < dafm_pkg::CHUNK_W; i++) begin
            for (int f = 0; f < dafm_pkg::NUM_SPLIT; f++) begin
              m16 = c.mask[f][cc*dafm_pkg::CHUNK_W +: dafm_pkg::CHUNK_W];
              rk = 5'($countones(m16 & ((16'd1 << i) - 16'd1)));
              if (m16[i] && p.fld[f][cc*dafm_pkg::CHUNK_W + 32'(rk[3:0])]) begin
                q.built[cc*dafm_pkg::CHUNK_W + i] = 1'b1;
              end
            end
          end
        end
        q.fld = '0;
        q.acc = '0;
        q.frank = '0;
      end
    end
    return q;
  endfunction

  dafm_pkg::pipe_t stage_r   [N];
  dafm_pkg::pipe_t stage_nxt [N];
  dafm_pkg::pipe_t in0;
  logic [N-1:0]    valid_r;
  logic            advance;

  assign advance   = !valid_r[N-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = valid_r[N-1];
  assign out_res   = stage_r[N-1];

  always_comb begin
    in0        = '0;
    in0.mode   = in_mode;
    in0.num    = in_bank_id_in;
    in0.fld[0] = in_phys_address;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stage_nxt[s] = stage_fn(s, in0, cfg);
    end else begin : g_rest
      assign stage_nxt[s] = stage_fn(s, stage_r[s-1], cfg);
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        stage_r[s] <= stage_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= {valid_r[N-2:0], in_valid};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dram_address_field_mapper.sv =====
// Throughput: one transaction per cycle; the 19-stage pipeline advances as one
// and holds in place while the result register waits for out_ready.
// Reset (synchronous, rst_n low) empties the pipeline and sets all bit tags
// to 0 and all radices to 1.
// Top level of the DRAM address field mapper; uses dafm_pkg, dafm_cfg, dafm_pipe.
`default_nettype none

`include "dram_address_field_mapper_assert.svh"

module dram_address_field_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dafm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dafm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_mode,
  input  wire logic [63:0]                     in_phys_address,
  input  wire logic [31:0]                     in_bank_id_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [63:0]                          out_channel,
  output logic [63:0]                          out_pseudo_channel,
  output logic [63:0]                          out_rank,
  output logic [63:0]                          out_bank_group,
  output logic [63:0]                          out_bank,
  output logic [63:0]                          out_row,
  output logic [63:0]                          out_column,
  output logic [63:0]                          out_cacheline,
  output logic [31:0]                          out_flat_bank_id,
  output logic [31:0]                          out_flat_rank_id,
  output logic [63:0]                          out_built_address
);

  dafm_pkg::cfg_t  cfg;
  dafm_pkg::pipe_t res;

  dafm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dafm_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_phys_address (in_phys_address),
    .in_bank_id_in   (in_bank_id_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res         (res)
  );

  assign out_channel        = res.fld[dafm_pkg::F_CH];
  assign out_pseudo_channel = res.fld[dafm_pkg::F_PCH];
  assign out_rank           = res.fld[dafm_pkg::F_RANK];
  assign out_bank_group     = res.fld[dafm_pkg::F_GROUP];
  assign out_bank           = res.fld[dafm_pkg::F_BANK];
  assign out_row            = res.fld[dafm_pkg::F_ROW];
  assign out_column         = res.fld[dafm_pkg::F_COL];
  assign out_cacheline      = res.fld[dafm_pkg::F_LINE];
  assign out_flat_bank_id   = res.acc;
  assign out_flat_rank_id   = res.frank;
  assign out_built_address  = res.built;

  `DAFM_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  `DAFM_ASSERT_NXT(a_stall_keeps_result, !in_ready, out_valid)
  `DAFM_ASSERT_IMP(a_built_excludes_ids, out_valid && out_built_address != 64'd0, out_flat_bank_id == 32'd0 && out_channel == 64'd0)
  `DAFM_ASSERT_IMP(a_zero_rank_id, out_valid && out_channel == 64'd0 && out_pseudo_channel == 64'd0 && out_rank == 64'd0, out_flat_rank_id == 32'd0)

endmodule

`default_nettype wire

// ===== sim/tb_dram_address_field_mapper.sv =====
// Testbench for the DRAM address field mapper: directed and random decode and
// build transactions checked against an in-bench predictor. Depends on dafm_pkg
// and the dram_address_field_mapper RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_dram_address_field_mapper;

  localparam int LATENCY = 19;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic {MODE_DECODE = 1'b0, MODE_BUILD = 1'b1} map_mode_e;
  typedef enum logic [3:0] {
    TAG_NONE = 4'd0, TAG_CH = 4'd1, TAG_PCH = 4'd2, TAG_RANK = 4'd3, TAG_GROUP = 4'd4,
    TAG_BANK = 4'd5, TAG_ROW = 4'd6, TAG_COL = 4'd7, TAG_LINE = 4'd8
  } tag_e;

  typedef struct {
    logic [63:0] fields [8];
    logic [31:0] flat_bank;
    logic [31:0] flat_rank;
    logic [63:0] built;
  } mapping_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dafm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dafm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [63:0] in_phys_address = '0;
  logic [31:0] in_bank_id_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_channel, out_pseudo_channel, out_rank, out_bank_group, out_bank;
  logic [63:0] out_row, out_column, out_cacheline, out_built_address;
  logic [31:0] out_flat_bank_id, out_flat_rank_id;

  logic [63:0] tag_regs [4];
  logic [8:0] radix_regs [4];
  mapping_t expected_mappings [$];
  int errors = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_off = 1'b0;

  dram_address_field_mapper dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [3:0] tag_of(int pos);
    logic [3:0] t;
    t = tag_regs[pos / 16][(pos % 16) * 4 +: 4];
    return (t > TAG_LINE) ? TAG_NONE : t;
  endfunction

  function automatic mapping_t predict_mapping(logic mode, logic [63:0] addr,
                                               logic [31:0] id_in);
    mapping_t m;
    logic [63:0] parts [9];
    int cnt [9];
    logic [63:0] b, g, r, p, id, rank_sz, pch_sz, ch_sz, fb, fr;
    int t;
    b = (radix_regs[0] == 0) ? 64'd1 : 64'(radix_regs[0]);
    g = (radix_regs[1] == 0) ? 64'd1 : 64'(radix_regs[1]);
    r = (radix_regs[2] == 0) ? 64'd1 : 64'(radix_regs[2]);
    p = (radix_regs[3] == 0) ? 64'd1 : 64'(radix_regs[3]);
    for (int i = 0; i < 9; i++) begin
      parts[i] = '0;
      cnt[i] = 0;
    end
    for (int i = 0; i < 8; i++) m.fields[i] = '0;
    m.flat_bank = '0;
    m.flat_rank = '0;
    m.built = '0;
    if (mode == MODE_DECODE) begin
      for (int pos = 0; pos < dafm_pkg::ADDR_BITS; pos++) begin
        t = tag_of(pos);
        if (t != TAG_NONE) begin
          if (addr[pos]) parts[t][cnt[t]] = 1'b1;
          cnt[t]++;
        end
      end
      for (int i = 1; i <= 8; i++) m.fields[i-1] = parts[i];
      fb = parts[5] + parts[4] * b + parts[3] * b * g + parts[2] * b * g * r
           + parts[1] * p * b * g * r;
      fr = parts[3] + parts[2] * r + parts[1] * p * r;
      m.flat_bank = fb[31:0];
      m.flat_rank = fr[31:0];
    end else begin
      id = 64'(id_in);
      rank_sz = b * g;
      pch_sz = rank_sz * r;
      ch_sz = pch_sz * p;
      parts[1] = id / ch_sz;
      id = id % ch_sz;
      parts[2] = id / pch_sz;
      id = id % pch_sz;
      parts[3] = id / rank_sz;
      id = id % rank_sz;
      parts[4] = id / b;
      parts[5] = id % b;
      for (int pos = 0; pos < dafm_pkg::ADDR_BITS; pos++) begin
        t = tag_of(pos);
        if (t != TAG_NONE && t <= TAG_BANK) begin
          if (cnt[t] < 64 && parts[t][cnt[t]]) m.built[pos] = 1'b1;
          cnt[t]++;
        end
      end
    end
    return m;
  endfunction

  task automatic write_reg(logic [dafm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < dafm_pkg::CFG_BANKS) tag_regs[idx[1:0]] = value;
    else radix_regs[2'(idx - dafm_pkg::CFG_BANKS)] = value[8:0];
    @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_mappings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_radices(logic [8:0] b, logic [8:0] g, logic [8:0] r, logic [8:0] p);
    write_reg(dafm_pkg::CFG_BANKS, 64'(b));
    write_reg(dafm_pkg::CFG_GROUPS, 64'(g));
    write_reg(dafm_pkg::CFG_RANKS, 64'(r));
    write_reg(dafm_pkg::CFG_PCHS, 64'(p));
  endtask

  task automatic send_item(logic mode, logic [63:0] addr, logic [31:0] id_in);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_phys_address <= addr;
    in_bank_id_in <= id_in;
    expected_mappings = {expected_mappings, predict_mapping(mode, addr, id_in)};
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_tag_reg(bit allow_unknown);
    logic [63:0] v;
    for (int k = 0; k < 16; k++)
      v[k*4 +: 4] = allow_unknown ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
    return v;
  endfunction

  // A realistic layout: line, column, bank, group, rank, pch, channel, then row.
  task automatic load_typical_map();
    logic [63:0] v [4];
    int pos;
    int widths [8];
    tag_e order [8];
    order = '{TAG_LINE, TAG_COL, TAG_BANK, TAG_GROUP, TAG_RANK, TAG_PCH, TAG_CH, TAG_ROW};
    for (int i = 0; i < 7; i++) widths[i] = $urandom_range(0, 4);
    widths[7] = 20;
    for (int i = 0; i < 4; i++) v[i] = '0;
    pos = 0;
    for (int f = 0; f < 8; f++)
      for (int w = 0; w < widths[f] && pos < 64; w++) begin
        v[pos / 16][(pos % 16) * 4 +: 4] = order[f];
        pos++;
      end
    for (int i = 0; i < 4; i++) write_reg(dafm_pkg::CFG_TAGS_0 + 4'(i), v[i]);
  endtask

  task automatic test_reset_defaults();
    send_item(MODE_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(MODE_BUILD, 64'd0, 32'hFFFF_FFFF);
    drain_pipe();
  endtask

  task automatic test_directed();
    write_reg(dafm_pkg::CFG_TAGS_0, 64'h8765_4321_8765_4321);
    write_reg(dafm_pkg::CFG_TAGS_1, 64'hFEDC_BA98_7654_3210);
    write_reg(dafm_pkg::CFG_TAGS_2, 64'h5555_4444_3333_2222);
    write_reg(dafm_pkg::CFG_TAGS_3, 64'h1111_9999_8888_7777);
    set_radices(9'd1, 9'd1, 9'd1, 9'd1);
    send_item(MODE_DECODE, 64'd0, 32'd0);
    send_item(MODE_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(MODE_DECODE, 64'hAAAA_5555_AAAA_5555, 32'hFFFF_FFFF);
    send_item(MODE_BUILD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_BUILD, 64'd0, 32'd0);
    drain_pipe();
    set_radices(9'd0, 9'd256, 9'd511, 9'd2);
    send_item(MODE_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(MODE_BUILD, 64'd0, 32'hFFFF_FFFF);
    send_item(MODE_BUILD, 64'd0, 32'h1234_5678);
    drain_pipe();
    set_radices(9'd256, 9'd256, 9'd256, 9'd256);
    send_item(MODE_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(MODE_BUILD, 64'd0, 32'hFFFF_FFFF);
    send_item(MODE_BUILD, 64'd0, 32'd1);
    drain_pipe();
    // All bits tagged channel: large gathered value with wrapped flat ids.
    for (int i = 0; i < 4; i++) write_reg(dafm_pkg::CFG_TAGS_0 + 4'(i), {16{TAG_CH}});
    set_radices(9'd3, 9'd5, 9'd7, 9'd9);
    send_item(MODE_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(MODE_DECODE, 64'h8000_0000_0000_0001, 32'd0);
    send_item(MODE_BUILD, 64'd0, 32'hFFFF_FFFF);
    drain_pipe();
  endtask

  task automatic test_random_maps(int phases, int per_phase, bit allow_unknown);
    for (int ph = 0; ph < phases; ph++) begin
      if ($urandom_range(0, 1)) load_typical_map();
      else for (int i = 0; i < 4; i++)
        write_reg(dafm_pkg::CFG_TAGS_0 + 4'(i), rand_tag_reg(allow_unknown));
      set_radices(9'($urandom_range(0, 511)), 9'($urandom_range(0, 16)),
                  9'($urandom_range(0, 8)), 9'($urandom_range(0, 511)));
      if (ph == 0) set_radices(9'd2, 9'd4, 9'd2, 9'd2);
      for (int n = 0; n < per_phase; n++)
        send_item(map_mode_e'($urandom_range(0, 1)), rand64(),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom());
      drain_pipe();
    end
  endtask

  task automatic test_backpressure();
    load_typical_map();
    hold_off = 1'b1;
    for (int n = 0; n < 60; n++) send_item(map_mode_e'($urandom_range(0, 1)), rand64(), $urandom());
    drain_pipe();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= 80) begin
        hold_off = 1'b0;
        idle_cycles = 0;
      end
    end else if (idle_cycles > 0) begin
      out_ready <= 1'b0;
      idle_cycles = idle_cycles - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      idle_cycles = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mapping_t m;
    logic [63:0] got [8];
    string names [8];
    names = '{"channel", "pseudo_channel", "rank", "bank_group", "bank", "row", "column",
              "cacheline"};
    if (rst_n && out_valid && out_ready) begin
      got = '{out_channel, out_pseudo_channel, out_rank, out_bank_group, out_bank, out_row,
              out_column, out_cacheline};
      if (expected_mappings.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        m = expected_mappings.pop_front();
        for (int i = 0; i < 8; i++)
          if (got[i] !== m.fields[i]) begin
            $error("%s: expected %h, actual %h", names[i], m.fields[i], got[i]);
            errors++;
          end
        if (out_flat_bank_id !== m.flat_bank) begin
          $error("flat_bank_id: expected %h, actual %h", m.flat_bank, out_flat_bank_id);
          errors++;
        end
        if (out_flat_rank_id !== m.flat_rank) begin
          $error("flat_rank_id: expected %h, actual %h", m.flat_rank, out_flat_rank_id);
          errors++;
        end
        if (out_built_address !== m.built) begin
          $error("built_address: expected %h, actual %h", m.built, out_built_address);
          errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_dram_address_field_mapper failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      tag_regs[i] = '0;
      radix_regs[i] = 9'd1;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_maps(5, 40, 1'b1);
    test_backpressure();
    test_random_maps(4, 40, 1'b0);
    gaps_on = 1'b0;
    test_random_maps(2, 30, 1'b1);
    if (errors != 0 || expected_mappings.size() != 0) begin
      if (expected_mappings.size() != 0) $error("results missing at end of run");
      $display("tb_dram_address_field_mapper failed");
    end else begin
      $display("tb_dram_address_field_mapper passed");
    end
    $finish;
  end

endmodule

`default_nettype wire
